[src/assert_macros.svh]
// Assertion macros shared by the RTL.
// Bodies compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SSA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");
`define SSA_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("%m: assertion failed");
`else
`define SSA_ASSERT(lbl, clk, rstn, prop)
`define SSA_ASSERT_NR(lbl, clk, prop)
`endif
`endif

[src/ssa_pkg.sv]
// Types, constants and float helpers for the sign-sketch attention score.
// No dependencies.
`default_nettype none
package ssa_pkg;
  localparam int LANES  = 8;
  localparam int PART_W = 12;
  localparam int SUM_W  = 15;
  localparam int ACC_W  = 17;

  typedef enum logic [1:0] {
    FN_QBYTES = 2'd0,
    FN_QSCALE = 2'd1,
    FN_KEY    = 2'd2,
    FN_NONE   = 2'd3
  } func_t;

  // sqrt(pi/2) as single: exponent 127, fraction below
  localparam logic [22:0] C_FRAC = 23'h206C99;
  localparam int          C_EXP0 = 127;
  localparam logic [31:0] QNAN_DEFAULT = 32'hFFC0_0000;

  // value = mant * 2^(exp - 150); bits holds the quietened NaN
  typedef struct packed {
    logic        sign;
    logic [8:0]  exp;
    logic [23:0] mant;
    logic        is_nan;
    logic        is_inf;
    logic        is_zero;
    logic [31:0] bits;
  } fop_t;

  function automatic fop_t unpack_f32(input logic [31:0] b);
    fop_t r;
    r.sign    = b[31];
    r.bits    = b | 32'h0040_0000;
    r.is_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    r.is_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    r.is_zero = (b[30:23] == 8'h00) && (b[22:0] == 23'd0);
    r.exp     = (b[30:23] == 8'h00) ? 9'd1 : {1'b0, b[30:23]};
    r.mant    = {(b[30:23] != 8'h00), b[22:0]};
    return r;
  endfunction

  function automatic fop_t from_int17(input logic signed [ACC_W-1:0] v);
    fop_t r;
    logic [ACC_W-1:0] mag;
    mag       = v[ACC_W-1] ? (~v + 17'd1) : v;
    r.sign    = v[ACC_W-1];
    r.bits    = 32'd0;
    r.is_nan  = 1'b0;
    r.is_inf  = 1'b0;
    r.is_zero = (v == 17'sd0);
    r.exp     = 9'd150;
    r.mant    = {7'd0, mag};
    return r;
  endfunction
endpackage
`default_nettype wire

[src/ssa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ssa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

[src/ssa_lane.sv]
// One lane: masked sum of eight int8 query bytes, registered.
// Depends on ssa_pkg.
`default_nettype none
module ssa_lane import ssa_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic [63:0]              qbytes,
  input  logic [7:0]               signs,
  output logic signed [PART_W-1:0] part_r
);
  logic signed [PART_W-1:0] part_nxt;
  logic signed [7:0]        b;

  always_comb begin
    part_nxt = '0;
    b        = '0;
    for (int i = 0; i < 8; i++) begin
      b = qbytes[8*i +: 8];
      if (signs[i]) begin
        part_nxt = part_nxt + PART_W'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      part_r <= part_nxt;
    end
  end
endmodule
`default_nettype wire

[src/ssa_merge.sv]
// Adder tree combining the lane partial dots.
// Depends on ssa_pkg.
`default_nettype none
module ssa_merge import ssa_pkg::*; (
  input  logic [LANES-1:0][PART_W-1:0] part,
  output logic signed [SUM_W-1:0]      sum
);
  always_comb begin
    sum = '0;
    for (int i = 0; i < LANES; i++) begin
      sum = sum + SUM_W'($signed(part[i]));
    end
  end
endmodule
`default_nettype wire

[src/ssa_fmul.sv]
// Four-stage IEEE single multiplier, round to nearest even, subnormals kept.
// Depends on ssa_pkg.
`default_nettype none
module ssa_fmul import ssa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  fop_t        a,
  input  fop_t        b,
  output logic        out_valid,
  output logic [31:0] out_bits
);
  // stage 1
  logic               sgn;
  logic               spec;
  logic [31:0]        sbits;
  logic signed [10:0] er;
  logic [47:0]        p;
  logic               v1_r, sign1_r, spec1_r;
  logic [31:0]        sbits1_r;
  logic signed [10:0] er1_r;
  logic [47:0]        p1_r;

  assign sgn = a.sign ^ b.sign;
  assign er  = $signed({2'b00, a.exp}) + $signed({2'b00, b.exp}) - 11'sd126;
  assign p   = a.mant * b.mant;

  always_comb begin
    spec  = 1'b1;
    sbits = '0;
    priority if (a.is_nan) begin
      sbits = a.bits;
    end else if (b.is_nan) begin
      sbits = b.bits;
    end else if ((a.is_inf && b.is_zero) || (a.is_zero && b.is_inf)) begin
      sbits = QNAN_DEFAULT;
    end else if (a.is_inf || b.is_inf) begin
      sbits = {sgn, 8'hFF, 23'd0};
    end else if (a.is_zero || b.is_zero) begin
      sbits = {sgn, 31'd0};
    end else begin
      spec = 1'b0;
    end
  end

  // stage 2: leading zero count, bytewise then across bytes
  logic [3:0]         blz [6];
  logic [7:0]         byt [6];
  logic [5:0]         lz;
  logic               v2_r, sign2_r, spec2_r;
  logic [31:0]        sbits2_r;
  logic signed [10:0] er2_r;
  logic [47:0]        p2_r;
  logic [5:0]         lz2_r;

  always_comb begin
    lz = 6'd48;
    for (int g = 0; g < 6; g++) begin
      byt[g] = p1_r[47-8*g -: 8];
      blz[g] = 4'd8;
      for (int k = 0; k < 8; k++) begin
        if (byt[g][k]) begin
          blz[g] = 4'(7 - k);
        end
      end
    end
    for (int g = 5; g >= 0; g--) begin
      if (byt[g] != 8'd0) begin
        lz = 6'(8 * g) + 6'(blz[g]);
      end
    end
  end

  // stage 3: normalise or denormalise
  logic signed [10:0] lim;
  logic signed [10:0] rs;
  logic [5:0]         sh;
  logic [47:0]        q;
  logic               st;
  logic signed [10:0] er3;
  logic               v3_r, sign3_r, spec3_r, st3_r;
  logic [31:0]        sbits3_r;
  logic signed [10:0] er3_r;
  logic [47:0]        q3_r;

  always_comb begin
    lim = er2_r - 11'sd1;
    rs  = 11'sd1 - er2_r;
    sh  = '0;
    q   = '0;
    st  = 1'b0;
    er3 = 11'sd1;
    if (er2_r >= 11'sd1) begin
      sh  = ($signed({5'd0, lz2_r}) > lim) ? lim[5:0] : lz2_r;
      q   = p2_r << sh;
      er3 = er2_r - $signed({5'd0, sh});
    end else if (rs > 11'sd48) begin
      st = |p2_r;
    end else begin
      q  = p2_r >> rs[5:0];
      st = |(p2_r << (6'd48 - rs[5:0]));
    end
  end

  // stage 4: round and pack
  logic [23:0]        m;
  logic               rnd;
  logic [24:0]        r;
  logic signed [10:0] ef;
  logic [31:0]        res;

  always_comb begin
    m   = q3_r[47:24];
    rnd = q3_r[23] & (st3_r | (|q3_r[22:0]) | m[0]);
    r   = {1'b0, m} + 25'(rnd);
    if (r[24]) begin
      ef = er3_r + 11'sd1;
    end else if (r[23]) begin
      ef = er3_r;
    end else begin
      ef = 11'sd0;
    end
    if (spec3_r) begin
      res = sbits3_r;
    end else if (ef >= 11'sd255) begin
      res = {sign3_r, 8'hFF, 23'd0};
    end else begin
      res = {sign3_r, ef[7:0], (r[24] ? 23'd0 : r[22:0])};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1_r      <= in_valid;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      out_valid <= v3_r;
    end
    sign1_r  <= sgn;
    spec1_r  <= spec;
    sbits1_r <= sbits;
    er1_r    <= er;
    p1_r     <= p;
    sign2_r  <= sign1_r;
    spec2_r  <= spec1_r;
    sbits2_r <= sbits1_r;
    er2_r    <= er1_r;
    p2_r     <= p1_r;
    lz2_r    <= lz;
    sign3_r  <= sign2_r;
    spec3_r  <= spec2_r;
    sbits3_r <= sbits2_r;
    er3_r    <= er3;
    q3_r     <= q;
    st3_r    <= st;
    out_bits <= res;
  end
endmodule
`default_nettype wire

[src/sign_sketch_int8_attention_score.sv]
// Top level of the sign-sketch int8 attention score block.
// Depends on ssa_pkg, ssa_ram, ssa_lane, ssa_merge, ssa_fmul, assert_macros.svh.
//
// Usage:
//   Input beats carry func, index, data and key_norm. func 0 loads eight
//   query bytes (chunk 0 restarts the query sum), func 1 loads the fp32
//   scale, func 2 streams one packed 64-bit key sign word. Out-of-range
//   indices and func 3 are dropped.
//   Query loads and the scale are written on acceptance. A key word runs
//   through lane RAM read, eight lane dots in parallel and a merge into the
//   accumulator. The last key word then runs three passes through one
//   four-stage float multiplier, and in_stall stays high until the result
//   register takes its result beat.
//   The result beat (score_bits, raw_dot) sits in an output register; new
//   input beats are taken while it waits, and only the next result waits
//   for a stalled output.
//   Reset clears the scale, query sum, accumulator and all control; query
//   bytes hold whatever was last written.
`default_nettype none
`include "assert_macros.svh"
module sign_sketch_int8_attention_score import ssa_pkg::*; #(
  parameter int SKETCH_DIM = 256
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_func,
  input  logic [4:0]              in_index,
  input  logic [63:0]             in_data,
  input  logic [15:0]             in_key_norm,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [31:0]             out_score_bits,
  output logic signed [ACC_W-1:0] out_raw_dot
);
  localparam int WORDS    = SKETCH_DIM / 64;
  localparam int CHUNKS   = SKETCH_DIM / 8;
  localparam int AW       = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int LOG2_DIM = $clog2(SKETCH_DIM);
  localparam logic [31:0] C_BITS = {1'b0, 8'(C_EXP0 - LOG2_DIM), C_FRAC};

  localparam logic [1:0] MS_NORM  = 2'd0;
  localparam logic [1:0] MS_SCALE = 2'd1;
  localparam logic [1:0] MS_RAW   = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DOT  = 5'b00010,
    S_MRG  = 5'b00100,
    S_MUL  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  func_t fn;
  logic  fire, chunk_ok, word_ok, q_we, key_go, out_free;
  assign fn       = func_t'(in_func);
  assign in_stall = (state_r != S_IDLE);
  assign fire     = in_valid && !in_stall;
  assign chunk_ok = 32'(in_index) < CHUNKS;
  assign word_ok  = 32'(in_index) < WORDS;
  assign q_we     = fire && (fn == FN_QBYTES) && chunk_ok;
  assign key_go   = fire && (fn == FN_KEY) && word_ok;

  logic signed [ACC_W-1:0] qsum_r, qsum_nxt, acc_r, acc_nxt, acc_new;
  logic signed [ACC_W-1:0] raw_r, raw_nxt;
  logic [31:0]             scale_r, prod_r, prod_nxt;
  logic [63:0]             sign_r;
  logic [15:0]             norm_r;
  logic                    first_r, last_r, issue_r, issue_nxt;
  logic [1:0]              mstep_r, mstep_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [31:0]             out_score_r;
  logic signed [ACC_W-1:0] out_raw_r;

  // query lanes
  logic [LANES-1:0][63:0]     qword;
  logic [LANES-1:0][PART_W-1:0] part;
  logic signed [SUM_W-1:0]    msum;

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    logic signed [PART_W-1:0] lane_part;

    ssa_ram #(.WIDTH(64), .DEPTH(WORDS)) u_ram (
      .clk   (clk),
      .we    (q_we && (in_index[2:0] == 3'(j))),
      .waddr (AW'(in_index >> 3)),
      .wdata (in_data),
      .re    (key_go),
      .raddr (AW'(in_index)),
      .rdata (qword[j])
    );

    ssa_lane u_lane (
      .clk    (clk),
      .en     (state_r == S_DOT),
      .qbytes (qword[j]),
      .signs  (sign_r[8*j +: 8]),
      .part_r (lane_part)
    );
    assign part[j] = lane_part;
  end

  ssa_merge u_merge (
    .part (part),
    .sum  (msum)
  );

  // chunk sum for query loads
  logic signed [10:0] csum;
  logic signed [7:0]  cb;
  always_comb begin
    csum = '0;
    cb   = '0;
    for (int i = 0; i < 8; i++) begin
      cb   = in_data[8*i +: 8];
      csum = csum + 11'(cb);
    end
  end

  // float multiplier
  fop_t        fa, fb;
  logic        mul_done;
  logic [31:0] mul_bits;

  always_comb begin
    unique case (mstep_r)
      MS_NORM: begin
        fa = unpack_f32(C_BITS);
        fb = unpack_f32({norm_r, 16'h0000});
      end
      MS_SCALE: begin
        fa = unpack_f32(prod_r);
        fb = unpack_f32(scale_r);
      end
      default: begin
        fa = unpack_f32(prod_r);
        fb = from_int17(raw_r);
      end
    endcase
  end

  ssa_fmul u_fmul (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (issue_r),
    .a         (fa),
    .b         (fb),
    .out_valid (mul_done),
    .out_bits  (mul_bits)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign acc_new  = first_r ? ACC_W'(msum) : acc_r + ACC_W'(msum);

  always_comb begin
    state_nxt = state_r;
    qsum_nxt  = qsum_r;
    acc_nxt   = acc_r;
    raw_nxt   = raw_r;
    prod_nxt  = prod_r;
    issue_nxt = 1'b0;
    mstep_nxt = mstep_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (q_we) begin
      qsum_nxt = (in_index == 5'd0) ? ACC_W'(csum) : qsum_r + ACC_W'(csum);
    end
    unique case (state_r)
      S_IDLE: begin
        if (key_go) begin
          state_nxt = S_DOT;
        end
      end
      S_DOT: state_nxt = S_MRG;
      S_MRG: begin
        acc_nxt = last_r ? '0 : acc_new;
        raw_nxt = {acc_new[ACC_W-2:0], 1'b0} - qsum_r;
        if (last_r) begin
          state_nxt = S_MUL;
          issue_nxt = 1'b1;
          mstep_nxt = MS_NORM;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          prod_nxt = mul_bits;
          if (mstep_r == MS_RAW) begin
            state_nxt = S_OUT;
          end else begin
            mstep_nxt = mstep_r + 2'd1;
            issue_nxt = 1'b1;
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      qsum_r      <= '0;
      acc_r       <= '0;
      scale_r     <= '0;
      issue_r     <= 1'b0;
      mstep_r     <= MS_NORM;
      out_valid_r <= 1'b0;
      first_r     <= 1'b0;
      last_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      qsum_r      <= qsum_nxt;
      acc_r       <= acc_nxt;
      issue_r     <= issue_nxt;
      mstep_r     <= mstep_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire && (fn == FN_QSCALE)) begin
        scale_r <= in_data[31:0];
      end
      if (key_go) begin
        first_r <= (in_index == 5'd0);
        last_r  <= (in_index == 5'(WORDS - 1));
      end
    end
    if (key_go) begin
      sign_r <= in_data;
      norm_r <= in_key_norm;
    end
    raw_r  <= raw_nxt;
    prod_r <= prod_nxt;
    if ((state_r == S_OUT) && out_free) begin
      out_score_r <= prod_r;
      out_raw_r   <= raw_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_score_bits = out_score_r;
  assign out_raw_dot    = out_raw_r;

  `SSA_ASSERT(a_mul_in_mul, clk, rst_n, mul_done |-> (state_r == S_MUL))
  `SSA_ASSERT(a_acc_clear, clk, rst_n, ((state_r == S_MRG) && last_r) |=> (acc_r == '0))
  `SSA_ASSERT(a_out_from_seq, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == S_OUT))
endmodule
`default_nettype wire
